// ----- hdl/rid_pkg.sv -----
// Shared types and codes for the replay id cache.
`default_nettype none
package rid_pkg;
	localparam int TIME_BITS = 63;
	localparam int SKEW_BITS = 16;

	localparam logic [1:0] VERDICT_FRESH  = 2'd0;
	localparam logic [1:0] VERDICT_REPLAY = 2'd1;
	localparam logic [1:0] VERDICT_EMPTY  = 2'd2;

	// scan token handed from cell to cell
	typedef struct packed {
		logic                 active;
		logic                 matched;
		logic                 have_old;
		logic [TIME_BITS-1:0] old_time;
	} scan_t;
endpackage
`default_nettype wire

// ----- hdl/rid_cell.sv -----
// One table entry: expiry, match and oldest check on the passing scan token.
`default_nettype none
module rid_cell
	import rid_pkg::*;
#(
	parameter int INDEX    = 0,
	parameter int IW       = 4,
	parameter int KEY_BITS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire scan_t                pin,
	input  wire logic [IW-1:0]        idx_in,
	input  wire logic [KEY_BITS-1:0]  key,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic [SKEW_BITS:0]   limit,
	input  wire logic                 wr_en,
	input  wire logic [IW-1:0]        wr_idx,
	output scan_t                     pout,
	output logic [IW-1:0]             idx_out,
	output logic                      live
);
	logic                 live_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [TIME_BITS-1:0] time_q;
	scan_t                pnext;
	logic [IW-1:0]        inext;
	logic                 here, expire;
	logic [TIME_BITS-1:0] age;

	assign here = pin.active && !pin.matched && live_q;
	assign age = now - time_q;
	assign expire = (now >= time_q) && (age > TIME_BITS'(limit));

	always_comb begin
		pnext = pin;
		inext = idx_in;
		if (here && !expire) begin
			if (key_q == key) begin
				pnext.matched = 1'b1;
			end else if (!pin.have_old || time_q < pin.old_time) begin
				pnext.have_old = 1'b1;
				pnext.old_time = time_q;
				inext = IW'(INDEX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			key_q <= '0;
			time_q <= '0;
			pout <= '0;
			idx_out <= '0;
		end else begin
			pout <= pnext;
			idx_out <= inext;
			if (wr_en && wr_idx == IW'(INDEX)) begin
				live_q <= 1'b1;
				key_q <= key;
				time_q <= now;
			end else if (here && expire) begin
				live_q <= 1'b0;
			end
		end
	end

	assign live = live_q;
endmodule
`default_nettype wire

// ----- hdl/replay_id_cache_unit.sv -----
// Replay id cache: a row of entry cells with a round-robin slot allocator.
//
// Input stream s_*: tuser = id_present, tdata = id_key, now_seconds.
// Output stream m_*: tdata = verdict (0 fresh, 1 replay, 2 empty id).
// cfg_we/cfg_wdata write skew_seconds; write it only while idle.
// An item with no id answers in the cycle after the accept and leaves the table alone.
// Any other item sends a scan token down the row of ENTRIES cells, one
// cell per cycle; each cell expires, matches or offers itself as oldest.
// A replay's verdict is registered once the token has left the last cell,
// and the next item can follow as that verdict is taken.
// A fresh key then searches free slots from the next pointer, one slot a
// cycle, and writes the first free slot, or the oldest entry if none is
// free; the fresh verdict is registered with that write.
// One item is in work at a time; s_tready is high only when idle and the
// result register is free or being taken, so a stalled receiver holds the
// verdict and blocks further input. Reset empties the table, sets the next
// pointer to zero and skew_seconds to 60.
`default_nettype none
module replay_id_cache_unit
	import rid_pkg::*;
#(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // id_key[63:0], now_seconds[126:64], pad
	input  wire logic         s_tuser,  // id_present
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [7:0]        m_tdata,  // verdict[1:0], pad
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_SCAN = 3'd1, ST_SRCH = 3'd2,
		ST_WRITE = 3'd3;

	logic [2:0]            st_q;
	logic [SKEW_BITS-1:0]  skew_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [SKEW_BITS:0]    limit_q;
	scan_t                 launch_q;
	logic [IW-1:0]         next_q, cnt_q, wslot_q, old_idx_q, slot;
	logic [IW:0]           sum;
	logic [1:0]            verdict_q;
	logic                  accept, wr_en, done;
	logic [ENTRIES-1:0]    live;
	scan_t                 chain [ENTRIES+1];
	logic [IW-1:0]         idx [ENTRIES+1];

	assign s_tready = (st_q == ST_IDLE) && (!m_tvalid || m_tready);
	assign accept = s_tvalid && s_tready;
	assign wr_en = (st_q == ST_WRITE);
	assign m_tdata = {6'd0, verdict_q};
	assign chain[0] = launch_q;
	assign idx[0] = '0;
	assign done = (accept && !s_tuser)
		|| (st_q == ST_SCAN && chain[ENTRIES].active && chain[ENTRIES].matched)
		|| (st_q == ST_WRITE);

	assign sum = {1'b0, next_q} + {1'b0, cnt_q};
	assign slot = (sum >= (IW+1)'(ENTRIES)) ? IW'(sum - (IW+1)'(ENTRIES)) : sum[IW-1:0];

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		rid_cell #(.INDEX(g), .IW(IW), .KEY_BITS(KEY_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.pin(chain[g]), .idx_in(idx[g]),
			.key(key_q), .now(now_q), .limit(limit_q),
			.wr_en(wr_en), .wr_idx(wslot_q),
			.pout(chain[g+1]), .idx_out(idx[g+1]), .live(live[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			skew_q <= 16'd60;
			launch_q <= '0;
			next_q <= '0;
			cnt_q <= '0;
			wslot_q <= '0;
			old_idx_q <= '0;
			m_tvalid <= 1'b0;
			verdict_q <= VERDICT_FRESH;
			key_q <= '0;
			now_q <= '0;
			limit_q <= '0;
		end else begin
			if (cfg_we) skew_q <= cfg_wdata;
			if (done) m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			launch_q.active <= accept && s_tuser;
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						key_q <= s_tdata[KEY_BITS-1:0];
						now_q <= s_tdata[126:64];
						limit_q <= {skew_q, 1'b0};
						if (!s_tuser) begin
							verdict_q <= VERDICT_EMPTY;
						end else begin
							st_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (chain[ENTRIES].active) begin
						if (chain[ENTRIES].matched) begin
							verdict_q <= VERDICT_REPLAY;
							st_q <= ST_IDLE;
						end else begin
							old_idx_q <= idx[ENTRIES];
							cnt_q <= '0;
							st_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (!live[slot]) begin
						wslot_q <= slot;
						st_q <= ST_WRITE;
					end else if (cnt_q == IW'(ENTRIES-1)) begin
						wslot_q <= old_idx_q;
						st_q <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRITE: begin
					next_q <= (wslot_q == IW'(ENTRIES-1)) ? '0 : wslot_q + 1'b1;
					verdict_q <= VERDICT_FRESH;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tuser |=> m_tvalid && verdict_q == VERDICT_EMPTY)
		else $error("empty id not answered");
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_WRITE |=> m_tvalid && verdict_q == VERDICT_FRESH && live[$past(wslot_q)])
		else $error("write did not record entry");
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= IW'(ENTRIES-1))
		else $error("next pointer out of range");
	a_token: assert property (@(posedge clk) disable iff (!arst_n)
		chain[ENTRIES].active |-> st_q == ST_SCAN)
		else $error("scan token outside scan");
`endif
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the replay id cache: stream driver, monitor and table predictor.
`timescale 1ns / 1ps
module testbench;
	import rid_pkg::*;

	localparam int ENTRIES = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic                 present;
		logic [63:0]          key;
		logic [TIME_BITS-1:0] now;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	request_t pending_requests[$];
	logic [1:0] expected_verdicts[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	bit driver_busy = 1'b0;
	bit in_accepted = 1'b0;

	// predictor state
	logic [15:0] tbl_skew;
	logic tbl_live[ENTRIES];
	logic [63:0] tbl_key[ENTRIES];
	logic [TIME_BITS-1:0] tbl_time[ENTRIES];
	int tbl_next;

	replay_id_cache_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [1:0] judge_request(request_t r);
		logic [64:0] limit;
		logic have_old;
		logic [TIME_BITS-1:0] old_time;
		int old_idx;
		int slot;
		if (!r.present)
			return VERDICT_EMPTY;
		limit = {48'd0, tbl_skew, 1'b0};
		have_old = 1'b0;
		old_time = '0;
		old_idx = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!tbl_live[i])
				continue;
			if (r.now >= tbl_time[i] && {2'b0, r.now - tbl_time[i]} > limit) begin
				tbl_live[i] = 1'b0;
				continue;
			end
			if (tbl_key[i] == r.key)
				return VERDICT_REPLAY;
			if (!have_old || tbl_time[i] < old_time) begin
				have_old = 1'b1;
				old_time = tbl_time[i];
				old_idx = i;
			end
		end
		slot = old_idx;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!tbl_live[(tbl_next + i) % ENTRIES]) begin
				slot = (tbl_next + i) % ENTRIES;
				break;
			end
		end
		tbl_live[slot] = 1'b1;
		tbl_key[slot] = r.key;
		tbl_time[slot] = r.now;
		tbl_next = (slot + 1) % ENTRIES;
		return VERDICT_FRESH;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_accepted) begin
				void'(pending_requests.pop_front());
				driver_busy = 1'b0;
			end
			if (!s_tvalid || in_accepted) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_requests[0].present;
					s_tdata <= {1'b0, pending_requests[0].now, pending_requests[0].key};
					driver_busy = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_accepted = s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				expected_verdicts.push_back(judge_request(
					'{present: s_tuser, key: s_tdata[63:0], now: s_tdata[126:64]}));
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected verdict %0d", m_tdata[1:0]);
				end else begin
					if (m_tdata[1:0] !== expected_verdicts[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("verdict mismatch: expected %0d got %0d",
								expected_verdicts[0], m_tdata[1:0]);
					end
					void'(expected_verdicts.pop_front());
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("replay_id_cache_unit verification failed");
				$finish;
			end
		end
	end

	function automatic request_t make_request(logic present, logic [63:0] key,
			logic [TIME_BITS-1:0] now);
		request_t r;
		r.present = present;
		r.key = key;
		r.now = now;
		return r;
	endfunction

	task automatic drain_all();
		while (pending_requests.size() > 0 || driver_busy || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (2 * ENTRIES + 8) @(posedge clk);
	endtask

	task automatic write_skew(logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tbl_skew = value;
	endtask

	// random traffic: keys from a small pool so replays, expiry and eviction occur
	task automatic queue_random(int count, logic [15:0] skew);
		logic [63:0] pool[8];
		logic [TIME_BITS-1:0] clock_now;
		logic [TIME_BITS-1:0] t;
		logic [63:0] k;
		clock_now = TIME_BITS'($urandom_range(1000));
		for (int i = 0; i < 8; i++)
			pool[i] = {$urandom, $urandom};
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: clock_now = clock_now - TIME_BITS'($urandom_range(20));
				1, 2: clock_now = clock_now + TIME_BITS'($urandom_range(3 * skew + 3));
				default: clock_now = clock_now + TIME_BITS'($urandom_range(3));
			endcase
			t = clock_now;
			if ($urandom_range(49) == 0)
				t = TIME_BITS'({$urandom, $urandom});
			if ($urandom_range(2) == 0)
				k = {$urandom, $urandom};
			else
				k = pool[$urandom_range(7)];
			pending_requests.push_back(make_request($urandom_range(19) != 0, k, t));
		end
	endtask

	initial begin
		logic [TIME_BITS-1:0] tmax;
		tmax = '1;
		tbl_skew = 16'd60;
		tbl_next = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_live[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_time[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty id, extremes, replay, expiry boundary, time backwards, eviction
		send_idle_pct = 9;
		recv_idle_pct = 69;
		pending_requests.push_back(make_request(1'b0, '1, tmax));
		pending_requests.push_back(make_request(1'b1, '0, '0));
		pending_requests.push_back(make_request(1'b1, '0, 63'd120));
		pending_requests.push_back(make_request(1'b1, '0, 63'd121));
		pending_requests.push_back(make_request(1'b1, '1, tmax));
		pending_requests.push_back(make_request(1'b1, '1, 63'd5));
		pending_requests.push_back(make_request(1'b0, 64'h0, 63'd5));
		for (int i = 0; i < 17; i++)
			pending_requests.push_back(make_request(1'b1, 64'h100 + i, tmax - 63'(i % 3)));
		drain_all();

		write_skew(16'd0);
		queue_random(150, 16'd0);
		drain_all();
		write_skew(16'hffff);
		queue_random(150, 16'hffff);
		drain_all();

		send_idle_pct = 69;
		recv_idle_pct = 9;
		write_skew(16'd3);
		queue_random(300, 16'd3);
		drain_all();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_skew(16'd60);
		queue_random(300, 16'd60);
		drain_all();

		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("replay_id_cache_unit verification clean");
		else
			$display("replay_id_cache_unit verification failed");
		$finish;
	end
endmodule
